FILE: src/psrq_pkg.sv
// Shared constants, types and codes of the point set radius query block.
`default_nettype none
package psrq_pkg;
	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int GROUP_W    = 6;
	localparam int NUM_GROUPS = 1 << GROUP_W;
	localparam int TAG_W      = 16;
	localparam int REQ_W      = 4;
	localparam int STATUS_W   = 2;
	localparam int RAD_W      = COORD_BITS;
	localparam int R2_W       = 2 * RAD_W;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int DIST_W     = SQ_W + 1;
	localparam int PT_W       = 2 * COORD_BITS + GROUP_W + TAG_W;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd2;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR        = 4'd0,
		REQ_APPEND       = 4'd1,
		REQ_NEAREST      = 4'd2,
		REQ_COUNT_IN     = 4'd3,
		REQ_COUNT_CIRCLE = 4'd4,
		REQ_COUNT_BOX    = 4'd5,
		REQ_REMOVE_IN    = 4'd6,
		REQ_REMOVE_GROUP = 4'd7,
		REQ_LIST         = 4'd8,
		REQ_LIST_MASKED  = 4'd9,
		REQ_LIST_GROUP   = 4'd10,
		REQ_GROUPS       = 4'd11,
		REQ_BBOX         = 4'd12
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [GROUP_W-1:0]           grp;
		logic [TAG_W-1:0]             tag;
	} point_t;

	// controller to datapath
	typedef struct packed {
		logic start;        // request word taken
		logic scan;         // store scan running
		logic pass2_start;  // restart scan for list output
		logic pass2;        // list output pass
		logic finish;       // load the single result word
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic list_hit;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

FILE: src/point_set_radius_query.sv
// Top level of the point set radius query block.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | req_type, query_x .. id_mask
//   out     | output    | out_valid / out_stall| status, count .. last
//
// Clear and append go straight to the result word, with no scan. A scan
// request reads the N stored points into the distance pipeline, N the number
// of stored points, one store read per cycle while the pipeline is not held.
// A list request with hits scans twice (count, then output); in the output
// pass any output stall holds the pipeline in place.
// Reset clears the point count; the store itself is not cleared.
`default_nettype none
module point_set_radius_query (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [psrq_pkg::REQ_W-1:0]             req_type,
	input  wire logic signed [psrq_pkg::COORD_BITS-1:0] query_x,
	input  wire logic signed [psrq_pkg::COORD_BITS-1:0] query_y,
	input  wire logic [psrq_pkg::RAD_W-1:0]             radius,
	input  wire logic signed [psrq_pkg::COORD_BITS-1:0] box_x_high,
	input  wire logic signed [psrq_pkg::COORD_BITS-1:0] box_y_high,
	input  wire logic [psrq_pkg::GROUP_W-1:0]           group_tag,
	input  wire logic [psrq_pkg::TAG_W-1:0]             point_tag,
	input  wire logic [psrq_pkg::TAG_W-1:0]             id_mask,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [psrq_pkg::STATUS_W-1:0]               status,
	output logic [psrq_pkg::CNT_W-1:0]                  count,
	output logic [psrq_pkg::IDX_W-1:0]                  index,
	output logic signed [psrq_pkg::COORD_BITS-1:0]      out_x,
	output logic signed [psrq_pkg::COORD_BITS-1:0]      out_y,
	output logic signed [psrq_pkg::COORD_BITS-1:0]      out_x_high,
	output logic signed [psrq_pkg::COORD_BITS-1:0]      out_y_high,
	output logic [psrq_pkg::GROUP_W-1:0]                out_group,
	output logic                                        last
);
	psrq_pkg::cmd_t cmd;
	psrq_pkg::sts_t sts;

	psrq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.req_type(req_type),
		.in_stall(in_stall),
		.cmd     (cmd),
		.sts     (sts)
	);

	psrq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_type  (req_type),
		.query_x   (query_x),
		.query_y   (query_y),
		.radius    (radius),
		.box_x_high(box_x_high),
		.box_y_high(box_y_high),
		.group_tag (group_tag),
		.point_tag (point_tag),
		.id_mask   (id_mask),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.count     (count),
		.index     (index),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_x_high(out_x_high),
		.out_y_high(out_y_high),
		.out_group (out_group),
		.last      (last)
	);
endmodule
`default_nettype wire

FILE: src/psrq_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module psrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: src/psrq_ctrl.sv
// Request sequencer: idle, scan, list output pass and single result.
`default_nettype none
module psrq_ctrl (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	input  wire logic [psrq_pkg::REQ_W-1:0]       req_type,
	output logic                                  in_stall,
	output psrq_pkg::cmd_t                        cmd,
	input  wire psrq_pkg::sts_t                   sts
);
	psrq_pkg::state_t state_q, state_nx;
	logic             direct;

	// clear, append and unused codes need no scan
	assign direct = (req_type == psrq_pkg::REQ_CLEAR) || (req_type == psrq_pkg::REQ_APPEND)
		|| (req_type > psrq_pkg::REQ_BBOX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psrq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			psrq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nx = direct ? psrq_pkg::ST_FINISH : psrq_pkg::ST_SCAN;
				end
			end
			psrq_pkg::ST_SCAN: begin
				if (sts.scan_done) begin
					state_nx = sts.list_hit ? psrq_pkg::ST_EMIT : psrq_pkg::ST_FINISH;
				end
			end
			psrq_pkg::ST_EMIT: begin
				if (sts.scan_done) begin
					state_nx = psrq_pkg::ST_IDLE;
				end
			end
			psrq_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					state_nx = psrq_pkg::ST_IDLE;
				end
			end
			default: state_nx = psrq_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall        = 1'b1;
		cmd             = '0;
		case (state_q)
			psrq_pkg::ST_IDLE: begin
				in_stall  = 1'b0;
				cmd.start = in_valid;
			end
			psrq_pkg::ST_SCAN: begin
				cmd.scan        = 1'b1;
				cmd.pass2_start = sts.scan_done && sts.list_hit;
			end
			psrq_pkg::ST_EMIT: begin
				cmd.scan  = 1'b1;
				cmd.pass2 = 1'b1;
			end
			psrq_pkg::ST_FINISH: begin
				cmd.finish = sts.out_free;
			end
			default: in_stall = 1'b1;
		endcase
	end
endmodule
`default_nettype wire

FILE: src/psrq_dp.sv
// Datapath: point store, distance pipeline, accumulators and output register.
`default_nettype none
module psrq_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire psrq_pkg::cmd_t                         cmd,
	output psrq_pkg::sts_t                              sts,
	input  wire logic [psrq_pkg::REQ_W-1:0]             req_type,
	input  wire logic signed [psrq_pkg::COORD_BITS-1:0] query_x,
	input  wire logic signed [psrq_pkg::COORD_BITS-1:0] query_y,
	input  wire logic [psrq_pkg::RAD_W-1:0]             radius,
	input  wire logic signed [psrq_pkg::COORD_BITS-1:0] box_x_high,
	input  wire logic signed [psrq_pkg::COORD_BITS-1:0] box_y_high,
	input  wire logic [psrq_pkg::GROUP_W-1:0]           group_tag,
	input  wire logic [psrq_pkg::TAG_W-1:0]             point_tag,
	input  wire logic [psrq_pkg::TAG_W-1:0]             id_mask,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [psrq_pkg::STATUS_W-1:0]               status,
	output logic [psrq_pkg::CNT_W-1:0]                  count,
	output logic [psrq_pkg::IDX_W-1:0]                  index,
	output logic signed [psrq_pkg::COORD_BITS-1:0]      out_x,
	output logic signed [psrq_pkg::COORD_BITS-1:0]      out_y,
	output logic signed [psrq_pkg::COORD_BITS-1:0]      out_x_high,
	output logic signed [psrq_pkg::COORD_BITS-1:0]      out_y_high,
	output logic [psrq_pkg::GROUP_W-1:0]                out_group,
	output logic                                        last
);
	localparam logic [psrq_pkg::CNT_W-1:0] FULL = psrq_pkg::CNT_W'(psrq_pkg::MAX_POINTS);
	localparam logic [psrq_pkg::CNT_W-1:0] ONE  = psrq_pkg::CNT_W'(1);

	// request word
	psrq_pkg::req_t                      req_q;
	logic signed [psrq_pkg::COORD_BITS-1:0] qx_q, qy_q, bxh_q, byh_q;
	logic [psrq_pkg::R2_W-1:0]           r2_q, r2;
	logic [psrq_pkg::GROUP_W-1:0]        grp_q;
	logic [psrq_pkg::TAG_W-1:0]          tag_q, mask_q;
	logic [psrq_pkg::CNT_W-1:0]          pc_q;

	// scan pipeline
	logic [psrq_pkg::CNT_W-1:0]          a_q;
	logic                                v_s0, v_s1;
	logic [psrq_pkg::IDX_W-1:0]          idx_s0, idx_s1;
	psrq_pkg::point_t                    rdata, pt_s1;
	logic [psrq_pkg::SQ_W-1:0]           sqx_s1, sqy_s1;
	logic                                inbox_s1;
	logic signed [psrq_pkg::DIFF_W-1:0]  dx, dy;
	logic signed [psrq_pkg::SQ_W-1:0]    sqx, sqy;
	logic                                adv, issue;
	logic [psrq_pkg::IDX_W-1:0]          raddr;

	// accumulators
	logic [psrq_pkg::CNT_W-1:0]          c_q, j_q, e_q;
	logic [psrq_pkg::DIST_W-1:0]         best_q;
	logic                                found_q, first_q;
	logic [psrq_pkg::IDX_W-1:0]          bi_q;
	psrq_pkg::point_t                    bpt_q;
	logic [psrq_pkg::NUM_GROUPS-1:0]     seen_q;
	logic signed [psrq_pkg::COORD_BITS-1:0] x0_q, y0_q, x1_q, y1_q;

	// evaluation
	logic [psrq_pkg::DIST_W-1:0]         d, r2x;
	logic                                strict, incl, grp_eq, match, eval, is_list, is_remove;
	logic                                out_free, emit;

	// RAM write
	logic                                we;
	logic [psrq_pkg::IDX_W-1:0]          waddr;
	psrq_pkg::point_t                    wdata;

	// result mux
	logic [psrq_pkg::STATUS_W-1:0]       f_status;
	logic [psrq_pkg::CNT_W-1:0]          f_count;
	logic [psrq_pkg::IDX_W-1:0]          f_index;
	logic signed [psrq_pkg::COORD_BITS-1:0] f_x, f_y, f_xh, f_yh;
	logic [psrq_pkg::GROUP_W-1:0]        f_group;

	function automatic logic [psrq_pkg::CNT_W-1:0] CNT_W_issue(input logic b);
		return {{(psrq_pkg::CNT_W - 1){1'b0}}, b};
	endfunction

	function automatic logic signed [psrq_pkg::DIFF_W-1:0] DIFF_W_ext(
		input logic signed [psrq_pkg::COORD_BITS-1:0] v);
		return {v[psrq_pkg::COORD_BITS-1], v};
	endfunction

	assign r2 = psrq_pkg::R2_W'(radius * radius);

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q  <= psrq_pkg::req_t'(req_type);
			qx_q   <= query_x;
			qy_q   <= query_y;
			r2_q   <= r2;
			bxh_q  <= box_x_high;
			byh_q  <= box_y_high;
			grp_q  <= group_tag;
			tag_q  <= point_tag;
			mask_q <= id_mask;
		end
	end

	// store
	psrq_ram #(
		.WIDTH(psrq_pkg::PT_W),
		.DEPTH(psrq_pkg::MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign out_free = !out_valid || !out_stall;
	assign r2x      = {{(psrq_pkg::DIST_W - psrq_pkg::R2_W){1'b0}}, r2_q};
	assign d        = {1'b0, sqx_s1} + {1'b0, sqy_s1};
	assign strict   = d < r2x;
	assign incl     = d <= r2x;
	assign grp_eq   = pt_s1.grp == grp_q;
	assign is_list  = (req_q == psrq_pkg::REQ_LIST) || (req_q == psrq_pkg::REQ_LIST_MASKED)
		|| (req_q == psrq_pkg::REQ_LIST_GROUP);
	assign is_remove = (req_q == psrq_pkg::REQ_REMOVE_IN) || (req_q == psrq_pkg::REQ_REMOVE_GROUP);

	// per point match of the running request
	always_comb begin
		case (req_q)
			psrq_pkg::REQ_COUNT_IN:     match = strict;
			psrq_pkg::REQ_COUNT_CIRCLE: match = incl;
			psrq_pkg::REQ_COUNT_BOX:    match = inbox_s1;
			psrq_pkg::REQ_REMOVE_IN:    match = strict;
			psrq_pkg::REQ_REMOVE_GROUP: match = grp_eq;
			psrq_pkg::REQ_LIST:         match = (d != '0) && incl;
			psrq_pkg::REQ_LIST_MASKED:  match = (d != '0) && incl && ((pt_s1.tag & mask_q) != '0);
			psrq_pkg::REQ_LIST_GROUP:   match = grp_eq;
			psrq_pkg::REQ_GROUPS:       match = !seen_q[pt_s1.grp];
			default:                    match = 1'b0;
		endcase
	end

	// pipeline holds while a list word waits for the output register
	assign emit  = cmd.pass2 && v_s1 && match;
	assign adv   = !(emit && !out_free);
	assign issue = cmd.scan && adv && (a_q < pc_q);
	assign raddr = adv ? a_q[psrq_pkg::IDX_W-1:0] : idx_s0;
	assign eval  = cmd.scan && !cmd.pass2 && v_s1;

	assign sts.scan_done = (a_q == pc_q) && !v_s0 && !v_s1;
	assign sts.list_hit  = is_list && (c_q != '0);
	assign sts.out_free  = out_free;

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q  <= '0;
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
		end else if (cmd.start || cmd.pass2_start) begin
			a_q  <= '0;
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
		end else if (adv) begin
			a_q  <= a_q + CNT_W_issue(issue);
			v_s0 <= issue;
			v_s1 <= v_s0 && cmd.scan;
		end
	end

	// differences and squares
	assign dx  = DIFF_W_ext(rdata.x) - DIFF_W_ext(qx_q);
	assign dy  = DIFF_W_ext(rdata.y) - DIFF_W_ext(qy_q);
	assign sqx = dx * dx;
	assign sqy = dy * dy;

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s0   <= a_q[psrq_pkg::IDX_W-1:0];
			idx_s1   <= idx_s0;
			pt_s1    <= rdata;
			sqx_s1   <= sqx;
			sqy_s1   <= sqy;
			inbox_s1 <= (rdata.x >= qx_q) && (rdata.x <= bxh_q)
				&& (rdata.y >= qy_q) && (rdata.y <= byh_q);
		end
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q     <= '0;
			j_q     <= '0;
			e_q     <= '0;
			found_q <= 1'b0;
			first_q <= 1'b1;
			seen_q  <= '0;
		end else if (cmd.start) begin
			c_q     <= '0;
			j_q     <= '0;
			e_q     <= '0;
			found_q <= 1'b0;
			first_q <= 1'b1;
			seen_q  <= '0;
		end else if (cmd.pass2_start) begin
			e_q <= '0;
		end else if (emit && out_free) begin
			e_q <= e_q + ONE;
		end else if (eval) begin
			if (match) begin
				c_q <= c_q + ONE;
			end
			if (is_remove && !match) begin
				j_q <= j_q + ONE;
			end
			if (req_q == psrq_pkg::REQ_GROUPS) begin
				seen_q[pt_s1.grp] <= 1'b1;
			end
			if (req_q == psrq_pkg::REQ_NEAREST && d < best_q) begin
				found_q <= 1'b1;
			end
			first_q <= 1'b0;
		end
	end

	// nearest and bounding box payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_q <= {{(psrq_pkg::DIST_W - psrq_pkg::R2_W){1'b0}}, r2};
		end else if (eval) begin
			if (req_q == psrq_pkg::REQ_NEAREST && d < best_q) begin
				best_q <= d;
				bi_q   <= idx_s1;
				bpt_q  <= pt_s1;
			end
			if (first_q || pt_s1.x < x0_q) x0_q <= pt_s1.x;
			if (first_q || pt_s1.x > x1_q) x1_q <= pt_s1.x;
			if (first_q || pt_s1.y < y0_q) y0_q <= pt_s1.y;
			if (first_q || pt_s1.y > y1_q) y1_q <= pt_s1.y;
		end
	end

	// store writes: compaction while removing, or append at the end
	always_comb begin
		if (cmd.finish) begin
			we    = (req_q == psrq_pkg::REQ_APPEND) && (pc_q < FULL);
			waddr = pc_q[psrq_pkg::IDX_W-1:0];
			wdata = '{x: qx_q, y: qy_q, grp: grp_q, tag: tag_q};
		end else begin
			we    = eval && is_remove && !match;
			waddr = j_q[psrq_pkg::IDX_W-1:0];
			wdata = pt_s1;
		end
	end

	// point count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (cmd.finish) begin
			case (req_q)
				psrq_pkg::REQ_CLEAR: pc_q <= '0;
				psrq_pkg::REQ_APPEND: begin
					if (pc_q < FULL) pc_q <= pc_q + ONE;
				end
				psrq_pkg::REQ_REMOVE_IN,
				psrq_pkg::REQ_REMOVE_GROUP: pc_q <= j_q;
				default: pc_q <= pc_q;
			endcase
		end
	end

	// single result word
	always_comb begin
		f_status = psrq_pkg::STATUS_OK;
		f_count  = '0;
		f_index  = '0;
		f_x      = '0;
		f_y      = '0;
		f_xh     = '0;
		f_yh     = '0;
		f_group  = '0;
		case (req_q)
			psrq_pkg::REQ_CLEAR: f_status = psrq_pkg::STATUS_OK;
			psrq_pkg::REQ_APPEND: begin
				if (pc_q >= FULL) begin
					f_status = psrq_pkg::STATUS_FULL;
					f_count  = pc_q;
				end else begin
					f_count = pc_q + ONE;
					f_index = pc_q[psrq_pkg::IDX_W-1:0];
				end
			end
			psrq_pkg::REQ_NEAREST: begin
				if (found_q) begin
					f_count = ONE;
					f_index = bi_q;
					f_x     = bpt_q.x;
					f_y     = bpt_q.y;
					f_group = bpt_q.grp;
				end else begin
					f_status = psrq_pkg::STATUS_NONE;
				end
			end
			psrq_pkg::REQ_REMOVE_IN,
			psrq_pkg::REQ_REMOVE_GROUP: begin
				f_count  = pc_q - j_q;
				f_status = (pc_q == j_q) ? psrq_pkg::STATUS_NONE : psrq_pkg::STATUS_OK;
			end
			psrq_pkg::REQ_COUNT_IN, psrq_pkg::REQ_COUNT_CIRCLE, psrq_pkg::REQ_COUNT_BOX,
			psrq_pkg::REQ_LIST, psrq_pkg::REQ_LIST_MASKED, psrq_pkg::REQ_LIST_GROUP,
			psrq_pkg::REQ_GROUPS: begin
				f_count  = c_q;
				f_status = (c_q == '0) ? psrq_pkg::STATUS_NONE : psrq_pkg::STATUS_OK;
			end
			psrq_pkg::REQ_BBOX: begin
				if (pc_q == '0) begin
					f_status = psrq_pkg::STATUS_NONE;
				end else begin
					f_count = pc_q;
					f_x     = x0_q;
					f_y     = y0_q;
					f_xh    = x1_q;
					f_yh    = y1_q;
				end
			end
			default: f_status = psrq_pkg::STATUS_NONE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish || (emit && out_free)) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status     <= f_status;
			count      <= f_count;
			index      <= f_index;
			out_x      <= f_x;
			out_y      <= f_y;
			out_x_high <= f_xh;
			out_y_high <= f_yh;
			out_group  <= f_group;
			last       <= 1'b1;
		end else if (emit && out_free) begin
			status     <= psrq_pkg::STATUS_OK;
			count      <= c_q;
			index      <= idx_s1;
			out_x      <= pt_s1.x;
			out_y      <= pt_s1.y;
			out_x_high <= '0;
			out_y_high <= '0;
			out_group  <= pt_s1.grp;
			last       <= (e_q + ONE) == c_q;
		end
	end
endmodule
`default_nettype wire

FILE: src/psrq_checker.sv
// Port level checks of the point set radius query block, bound to the top level.
`default_nettype none
module psrq_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_stall,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic [psrq_pkg::STATUS_W-1:0]      status,
	input wire logic [psrq_pkg::CNT_W-1:0]         count,
	input wire logic [psrq_pkg::IDX_W-1:0]         index,
	input wire logic                               last
);
	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(count) && $stable(index)
		&& $stable(last))
		else $error("output word changed under stall");

	// a list in progress keeps the input side closed
	a_list_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input open during a list");

	// full store reports the full count
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == psrq_pkg::STATUS_FULL
		|-> count == psrq_pkg::CNT_W'(psrq_pkg::MAX_POINTS))
		else $error("full status with wrong count");

	// nothing found carries a zero count and ends the request
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == psrq_pkg::STATUS_NONE |-> count == '0 && last)
		else $error("empty result malformed");
endmodule

bind point_set_radius_query psrq_checker u_psrq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.status   (status),
	.count    (count),
	.index    (index),
	.last     (last)
);
`default_nettype wire
